FILE: src/next_fit_free_list_allocator_core_assert.svh
// Assertion macros for the allocator core.
`ifndef NEXT_FIT_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define NEXT_FIT_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define NFA_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define NFA_ASSERT_RESET(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("reset check failed");
`else
`define NFA_ASSERT_IMPL(label, clk, rst_n, prop)
`define NFA_ASSERT_RESET(label, clk, prop)
`endif
`endif

FILE: src/nfa_pkg.sv
package nfa_pkg;
    localparam int ARENA_UNITS_DEF = 4096;
    localparam int GROW_UNITS_DEF  = 1024;
    localparam int UNIT_BYTES      = 8;
    localparam int ADDR_W          = 15;
    localparam logic FUNC_ALLOC    = 1'b0;
    localparam logic FUNC_FREE     = 1'b1;
    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_OOM    = 1'b1;

    typedef struct packed {
        logic                func;
        logic [ADDR_W-1:0]   request_bytes;
        logic [ADDR_W-1:0]   block_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0]   address;
        logic                status;
    } t_rsp;
endpackage

FILE: src/nfa_if.sv
interface nfa_req_if;
    logic               valid;
    logic               ready;
    nfa_pkg::t_req      payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface nfa_rsp_if;
    logic               valid;
    logic               ready;
    nfa_pkg::t_rsp      payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: src/nfa_ram.sv
module nfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: src/nfa_alu.sv
// Shared unit: one add or subtract, an equal compare and a greater-or-equal compare per cycle.
module nfa_alu #(
    parameter int W = 14
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W:0]   o_res,
    output logic         o_eq,
    output logic         o_ge
);
    assign o_res = i_sub ? ({1'b0, i_a} - {1'b0, i_b}) : ({1'b0, i_a} + {1'b0, i_b});
    assign o_eq  = (i_a == i_b);
    assign o_ge  = (i_a >= i_b);
endmodule

FILE: src/next_fit_free_list_allocator_core.sv
// Operation: an allocate walks the free list from the rover, and the first allocate first builds
// the list. A growth inserts its new block by a walk of the list. A free walks the list to insert
// its block, or goes straight to the response when it is ignored.
// Throughput: one transaction at a time; the next is taken in the cycle after the response.
// Reset: rover, break and list-built flag clear; the header RAM is not cleared.
module next_fit_free_list_allocator_core #(
    parameter int ARENA_UNITS = nfa_pkg::ARENA_UNITS_DEF,
    parameter int GROW_UNITS  = nfa_pkg::GROW_UNITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    nfa_req_if.sink  i_req,
    nfa_rsp_if.source o_rsp
);
    import nfa_pkg::*;
    `include "next_fit_free_list_allocator_core_assert.svh"

    localparam int IW = $clog2(ARENA_UNITS + 1);
    localparam int AW = IW + 1;
    localparam int HW = 2 * IW;
    localparam logic [IW-1:0] SENT = IW'(ARENA_UNITS);
    localparam logic [AW-1:0] WALK_LIMIT = AW'(2 * (ARENA_UNITS + 2));
    localparam int ADDR_UNITS = 32768 / UNIT_BYTES;
    localparam int UB_SH = $clog2(UNIT_BYTES);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RSP  = 5'd1;
    localparam logic [4:0] S_T_RD_PREV = 5'd2;
    localparam logic [4:0] S_T_PREV    = 5'd3;
    localparam logic [4:0] S_T_RD_P    = 5'd4;
    localparam logic [4:0] S_T_P       = 5'd5;
    localparam logic [4:0] S_T_UNLINK  = 5'd6;
    localparam logic [4:0] S_T_SPLIT   = 5'd7;
    localparam logic [4:0] S_T_SPLIT2  = 5'd8;
    localparam logic [4:0] S_T_NEXT    = 5'd9;
    localparam logic [4:0] S_G_RD      = 5'd10;
    localparam logic [4:0] S_G_WR      = 5'd11;
    localparam logic [4:0] S_P_RD_P    = 5'd12;
    localparam logic [4:0] S_P_P       = 5'd13;
    localparam logic [4:0] S_P_RD_BP   = 5'd14;
    localparam logic [4:0] S_P_BP      = 5'd15;
    localparam logic [4:0] S_P_RD_Q    = 5'd16;
    localparam logic [4:0] S_P_Q       = 5'd17;
    localparam logic [4:0] S_P_WR_BP   = 5'd18;
    localparam logic [4:0] S_P_RD_BP2  = 5'd19;
    localparam logic [4:0] S_P_BP2     = 5'd20;
    localparam logic [4:0] S_P_WR_P    = 5'd21;
    localparam logic [4:0] S_T_INIT    = 5'd22;
    localparam logic [4:0] S_P_CHK     = 5'd23;

    logic [4:0]      r_state, n_state;
    logic [IW-1:0]   r_rover, n_rover;
    logic [IW-1:0]   r_brk, n_brk;
    logic            r_started, n_started;
    logic            r_from_take, n_from_take;
    logic [IW-1:0]   r_need, n_need;
    logic [IW-1:0]   r_prev, n_prev;
    logic [IW-1:0]   r_p, n_p;
    logic [IW-1:0]   r_bp, n_bp;
    logic [IW-1:0]   r_q, n_q;
    logic [IW-1:0]   r_lnk, n_lnk;
    logic [IW-1:0]   r_sz, n_sz;
    logic [IW-1:0]   r_bsz, n_bsz;
    logic [IW-1:0]   r_blnk, n_blnk;
    logic [AW-1:0]   r_n, n_n;
    logic [AW-1:0]   r_pn, n_pn;
    t_rsp            r_rsp, n_rsp;

    logic            w_we;
    logic [IW-1:0]   w_waddr, w_raddr;
    logic [HW-1:0]   w_wdata, w_rdata;
    logic [IW-1:0]   w_rd_lnk, w_rd_sz;
    logic [IW-1:0]   w_a, w_b;
    logic            w_sub;
    logic [IW:0]     w_res;
    logic            w_eq, w_ge;

    function automatic logic [IW-1:0] f_safe(input logic [IW-1:0] x);
        return (x <= SENT) ? x : SENT;
    endfunction

    nfa_ram #(.WIDTH(HW), .DEPTH(ARENA_UNITS + 1)) u_hdr (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    nfa_alu #(.W(IW)) u_alu (
        .i_a   (w_a),
        .i_b   (w_b),
        .i_sub (w_sub),
        .o_res (w_res),
        .o_eq  (w_eq),
        .o_ge  (w_ge)
    );

    assign w_rd_lnk = w_rdata[HW-1:IW];
    assign w_rd_sz  = w_rdata[IW-1:0];

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = (r_state == S_RSP);
    assign o_rsp.payload = r_rsp;

    always_comb begin
        logic [ADDR_W:0]   v_req_u;
        logic [IW:0]       v_nu;
        logic [AW:0]       v_sum;
        logic [ADDR_W:0]   v_bpu;
        v_req_u = '0;
        v_nu    = '0;
        v_sum   = '0;
        v_bpu   = '0;
        n_state = r_state;
        n_rover = r_rover;
        n_brk = r_brk;
        n_started = r_started;
        n_from_take = r_from_take;
        n_need = r_need;
        n_prev = r_prev;
        n_p = r_p;
        n_bp = r_bp;
        n_q = r_q;
        n_lnk = r_lnk;
        n_sz = r_sz;
        n_bsz = r_bsz;
        n_blnk = r_blnk;
        n_n = r_n;
        n_pn = r_pn;
        n_rsp = r_rsp;
        w_we = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        w_raddr = '0;
        w_a = '0;
        w_b = '0;
        w_sub = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_rsp = '{address: '0, status: STATUS_DONE};
                    n_n = '0;
                    if (i_req.payload.func == FUNC_ALLOC) begin
                        v_req_u = ({1'b0, i_req.payload.request_bytes}
                                   + (ADDR_W + 1)'(UNIT_BYTES - 1)) >> UB_SH;
                        n_need = IW'(v_req_u + (ADDR_W + 1)'(1));
                        n_from_take = 1'b1;
                        n_state = r_started ? S_T_RD_PREV : S_T_INIT;
                    end else begin
                        v_bpu = ((ADDR_W + 1)'(i_req.payload.block_address >> UB_SH)
                                 + (ADDR_W + 1)'(ADDR_UNITS - 1)) & (ADDR_W + 1)'(ADDR_UNITS - 1);
                        n_from_take = 1'b0;
                        if (r_started && ({1'b0, v_bpu} < (ADDR_W + 2)'(r_brk))
                                && ({1'b0, v_bpu} < (ADDR_W + 2)'(SENT))) begin
                            n_bp = IW'(v_bpu);
                            n_state = S_P_RD_P;
                        end else begin
                            n_state = S_RSP;
                        end
                    end
                end
            end
            S_T_INIT: begin
                w_we = 1'b1;
                w_waddr = SENT;
                w_wdata = {SENT, {IW{1'b0}}};
                n_rover = SENT;
                n_started = 1'b1;
                n_state = S_T_RD_PREV;
            end
            S_T_RD_PREV: begin
                n_prev = f_safe(r_rover);
                w_raddr = f_safe(r_rover);
                n_state = S_T_PREV;
            end
            S_T_PREV: begin
                n_bsz = w_rd_sz;
                n_p = f_safe(w_rd_lnk);
                w_raddr = f_safe(w_rd_lnk);
                n_state = S_T_P;
            end
            S_T_RD_P: begin
                w_raddr = r_p;
                n_state = S_T_P;
            end
            S_T_P: begin
                n_lnk = w_rd_lnk;
                n_sz = w_rd_sz;
                w_a = w_rd_sz;
                w_b = r_need;
                if (w_ge) begin
                    n_state = w_eq ? S_T_UNLINK : S_T_SPLIT;
                end else if (r_p == f_safe(r_rover)) begin
                    n_state = S_G_RD;
                end else begin
                    n_state = S_T_NEXT;
                end
            end
            S_T_UNLINK: begin
                w_we = 1'b1;
                w_waddr = r_prev;
                w_raddr = r_prev;
                w_wdata = {f_safe(r_lnk), r_bsz};
                n_state = S_T_SPLIT2;
            end
            S_T_SPLIT: begin
                w_a = r_sz;
                w_b = r_need;
                w_sub = 1'b1;
                n_sz = w_res[IW-1:0];
                n_state = S_T_SPLIT2;
                n_blnk = '1;
            end
            S_T_SPLIT2: begin
                n_state = S_RSP;
            end
            S_T_NEXT: begin
                // The entry just visited becomes the predecessor, so its size is kept.
                n_bsz = r_sz;
                n_prev = r_p;
                n_p = f_safe(r_lnk);
                n_n = r_n + AW'(1);
                n_state = (r_n + AW'(1) > WALK_LIMIT) ? S_RSP : S_T_RD_P;
                if (r_n + AW'(1) > WALK_LIMIT) begin
                    n_rsp = '{address: '0, status: STATUS_OOM};
                end
            end
            S_G_RD: begin
                v_nu = (r_need < IW'(GROW_UNITS)) ? (IW + 1)'(GROW_UNITS) : {1'b0, r_need};
                w_a = SENT;
                w_b = r_brk;
                w_sub = 1'b1;
                if ({1'b0, r_brk} > (IW + 1)'(SENT) || v_nu > w_res) begin
                    n_rsp = '{address: '0, status: STATUS_OOM};
                    n_state = S_RSP;
                end else begin
                    n_bp = r_brk;
                    n_bsz = IW'(v_nu);
                    n_brk = IW'({1'b0, r_brk} + v_nu);
                    n_state = S_G_WR;
                end
            end
            S_G_WR: begin
                w_we = 1'b1;
                w_waddr = r_bp;
                w_wdata = {{IW{1'b0}}, r_bsz};
                n_from_take = 1'b1;
                n_state = S_P_RD_P;
            end
            S_P_RD_P: begin
                n_p = f_safe(r_rover);
                w_raddr = f_safe(r_rover);
                n_pn = '0;
                n_state = S_P_P;
            end
            S_P_P: begin
                n_q = f_safe(w_rd_lnk);
                n_state = S_P_CHK;
            end
            S_P_CHK: begin
                if ((r_bp > r_p && r_bp < r_q)
                        || (r_p >= r_q && (r_bp > r_p || r_bp < r_q))) begin
                    w_raddr = r_bp;
                    n_state = S_P_BP;
                end else if (r_pn + AW'(1) > WALK_LIMIT) begin
                    // The insertion is dropped; an allocate goes on from the old rover.
                    n_p = f_safe(r_rover);
                    n_state = S_P_WR_P;
                end else begin
                    n_p = r_q;
                    w_raddr = r_q;
                    n_pn = r_pn + AW'(1);
                    n_state = S_P_P;
                end
            end
            S_P_BP: begin
                n_bsz = w_rd_sz;
                w_raddr = r_q;
                n_state = S_P_Q;
            end
            S_P_Q: begin
                w_a = r_bp;
                w_b = r_bsz;
                if (r_q != SENT && w_res == {1'b0, r_q}) begin
                    n_bsz = IW'(r_bsz + w_rd_sz);
                    n_blnk = f_safe(w_rd_lnk);
                end else begin
                    n_blnk = r_q;
                end
                n_state = S_P_WR_BP;
            end
            S_P_WR_BP: begin
                w_we = 1'b1;
                w_waddr = r_bp;
                w_wdata = {r_blnk, r_bsz};
                w_raddr = r_p;
                n_state = S_P_BP2;
            end
            S_P_BP2: begin
                w_a = r_p;
                w_b = w_rd_sz;
                w_we = 1'b1;
                w_waddr = r_p;
                if (r_p != SENT && w_res == {1'b0, r_bp}) begin
                    w_wdata = {r_blnk, IW'(w_rd_sz + r_bsz)};
                end else begin
                    w_wdata = {r_bp, w_rd_sz};
                end
                n_rover = r_p;
                n_state = S_P_WR_P;
            end
            S_P_WR_P: begin
                if (r_from_take) begin
                    n_p = r_p;
                    n_n = r_n + AW'(1);
                    n_prev = r_p;
                    w_raddr = r_p;
                    n_state = S_P_RD_BP2;
                end else begin
                    n_state = S_RSP;
                end
            end
            S_P_RD_BP2: begin
                n_bsz = w_rd_sz;
                n_p = f_safe(w_rd_lnk);
                n_state = (r_n > WALK_LIMIT) ? S_RSP : S_T_RD_P;
                if (r_n > WALK_LIMIT) begin
                    n_rsp = '{address: '0, status: STATUS_OOM};
                end
            end
            S_RSP: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Completion of an allocate: unlink or split, both leave here with a response.
        if (r_state == S_T_SPLIT) begin
            v_sum = (AW + 1)'(r_p) + (AW + 1)'(w_res[IW-1:0]);
            if (v_sum >= (AW + 1)'(SENT)) begin
                n_rsp = '{address: '0, status: STATUS_OOM};
                n_state = S_RSP;
            end else begin
                w_we = 1'b1;
                w_waddr = r_p;
                w_wdata = {r_lnk, w_res[IW-1:0]};
                n_p = IW'(v_sum);
            end
        end
        if (r_state == S_T_SPLIT2 && r_blnk == '1 && r_from_take) begin
            w_we = 1'b1;
            w_waddr = r_p;
            w_wdata = {w_rd_lnk, r_need};
        end
        if (r_state == S_T_SPLIT2 || (r_state == S_T_SPLIT && n_state == S_T_SPLIT2)) begin
            if (r_state == S_T_SPLIT2) begin
                n_rover = r_prev;
                n_rsp = '{address: ADDR_W'((AW + UB_SH)'(r_p + AW'(1)) << UB_SH),
                          status: STATUS_DONE};
            end
        end
        if (r_state == S_T_P && n_state != S_T_P) begin
            n_bsz = r_bsz;
            n_blnk = '0;
        end
        if (r_state == S_T_P && w_ge && w_eq) begin
            n_blnk = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rover <= '0;
            r_brk <= '0;
            r_started <= 1'b0;
            r_n <= '0;
        end else begin
            r_state <= n_state;
            r_rover <= n_rover;
            r_brk <= n_brk;
            r_started <= n_started;
            r_n <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_from_take <= n_from_take;
        r_need <= n_need;
        r_prev <= n_prev;
        r_p <= n_p;
        r_bp <= n_bp;
        r_q <= n_q;
        r_lnk <= n_lnk;
        r_sz <= n_sz;
        r_bsz <= n_bsz;
        r_blnk <= n_blnk;
        r_pn <= n_pn;
        r_rsp <= n_rsp;
    end

    `NFA_ASSERT_IMPL(a_rsp_only_after_work, i_clk, i_rst_n,
        (o_rsp.valid && !o_rsp.ready) |=> o_rsp.valid)
    `NFA_ASSERT_IMPL(a_no_accept_while_busy, i_clk, i_rst_n,
        o_rsp.valid |-> !i_req.ready)
    `NFA_ASSERT_IMPL(a_break_in_arena, i_clk, i_rst_n, r_brk <= SENT)
    `NFA_ASSERT_RESET(a_reset_idle, i_clk, !$past(i_rst_n) |-> i_req.ready || !i_rst_n)
endmodule
